FILE: hdl/gcd_pkg.sv
package gcd_pkg;

    localparam int CW     = 24;          // coordinate width
    localparam int CFG_W  = 16;          // configuration register width
    localparam int D      = CW + 1;      // coordinate difference
    localparam int P      = 2 * D;       // product of two differences
    localparam int S      = P + 1;       // sum of two products
    localparam int MW     = P;           // magnitude of a projection term
    localparam int H      = MW / 2;      // low split of a magnitude
    localparam int HI     = MW - H;      // high split of a magnitude
    localparam int SQ     = 2 * MW;      // square of a magnitude
    localparam int R2W    = 2 * CFG_W;   // squared radius

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CKPT = 2'd1,
        KIND_GATE = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_RADIUS    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind kind;
        logic  box_rej;
        logic  zero_gate;
        logic  hit_geo;
        logic  cp_hit;
        logic  dp_neg;
        logic  ep_pos;
        logic  dc_neg;
        logic  ec_pos;
    } t_flags;

    typedef struct packed {
        t_flags            flags;
        logic [MW-1:0]     mag_dp;
        logic [MW-1:0]     mag_ep;
        logic [MW-1:0]     mag_dc;
        logic [MW-1:0]     mag_ec;
        logic [MW-1:0]     l2;
        logic [R2W-1:0]    r2;
    } t_geom;

endpackage

FILE: hdl/gcd_sq.sv
module gcd_sq (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [gcd_pkg::MW-1:0]  i_mag,
    output logic [gcd_pkg::SQ-1:0]  o_sq
);
    import gcd_pkg::*;

    // The magnitude is split in two halves; three partial products are
    // formed in the first stage and summed in the second.
    logic [HI-1:0]     w_hi;
    logic [H-1:0]      w_lo;
    logic [2*HI-1:0]   r_hh;
    logic [HI+H-1:0]   r_hl;
    logic [2*H-1:0]    r_ll;
    logic [SQ-1:0]     r_sq;

    assign w_hi = i_mag[MW-1:H];
    assign w_lo = i_mag[H-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= w_hi * w_hi;
            r_hl <= w_hi * w_lo;
            r_ll <= w_lo * w_lo;
            r_sq <= (SQ'(r_hh) << (2 * H)) + (SQ'(r_hl) << (H + 1)) + SQ'(r_ll);
        end
    end

    assign o_sq = r_sq;

endmodule

FILE: hdl/gcd_geom.sv
module gcd_geom (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  gcd_pkg::t_kind             i_kind,
    input  logic [10*gcd_pkg::CW-1:0]  i_coord,
    input  logic [gcd_pkg::CFG_W-1:0]  i_threshold,
    input  logic [gcd_pkg::CFG_W-1:0]  i_radius,
    output logic                       o_valid,
    output gcd_pkg::t_geom             o_geom
);
    import gcd_pkg::*;

    function automatic logic signed [D-1:0] dif(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b);
        return D'(a) - D'(b);
    endfunction

    function automatic logic in_box(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                    logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
                                    logic signed [CW-1:0] px, logic signed [CW-1:0] py);
        return (px >= ((ax < bx) ? ax : bx)) && (px <= ((ax > bx) ? ax : bx)) &&
               (py >= ((ay < by) ? ay : by)) && (py <= ((ay > by) ? ay : by));
    endfunction

    function automatic logic opp(logic signed [S-1:0] u, logic signed [S-1:0] v);
        return ((u > 0) && (v < 0)) || ((u < 0) && (v > 0));
    endfunction

    logic signed [CW-1:0] pvx, pvy, cux, cuy, lfx, lfy, rtx, rty, cpx, cpy;
    logic signed [D-1:0]  w_rad, w_minx, w_maxx, w_miny, w_maxy;
    logic signed [D-1:0]  w_pvx, w_pvy, w_cux, w_cuy;
    logic                 w_box;

    assign pvx = i_coord[0*CW +: CW];
    assign pvy = i_coord[1*CW +: CW];
    assign cux = i_coord[2*CW +: CW];
    assign cuy = i_coord[3*CW +: CW];
    assign lfx = i_coord[4*CW +: CW];
    assign lfy = i_coord[5*CW +: CW];
    assign rtx = i_coord[6*CW +: CW];
    assign rty = i_coord[7*CW +: CW];
    assign cpx = i_coord[8*CW +: CW];
    assign cpy = i_coord[9*CW +: CW];

    assign w_rad  = $signed(D'(i_radius));
    assign w_minx = D'((lfx < rtx) ? lfx : rtx) - w_rad;
    assign w_maxx = D'((lfx > rtx) ? lfx : rtx) + w_rad;
    assign w_miny = D'((lfy < rty) ? lfy : rty) - w_rad;
    assign w_maxy = D'((lfy > rty) ? lfy : rty) + w_rad;
    assign w_pvx  = D'(pvx);
    assign w_pvy  = D'(pvy);
    assign w_cux  = D'(cux);
    assign w_cuy  = D'(cuy);
    assign w_box  = ((w_pvx < w_minx) && (w_cux < w_minx)) ||
                    ((w_pvx > w_maxx) && (w_cux > w_maxx)) ||
                    ((w_pvy < w_miny) && (w_cuy < w_miny)) ||
                    ((w_pvy > w_maxy) && (w_cuy > w_maxy));

    // Stage 1: differences and comparison flags.
    logic                r_v1;
    t_flags              r_f1;
    logic                r_ib_pv1, r_ib_cu1, r_ib_lf1, r_ib_rt1;
    logic signed [D-1:0] r_gx, r_gy, r_pdx, r_pdy, r_cdx, r_cdy, r_mx, r_my;
    logic signed [D-1:0] r_lpx, r_lpy, r_rpx, r_rpy, r_kpx, r_kpy, r_kcx, r_kcy;

    // Stage 2: products.
    logic                r_v2;
    t_flags              r_f2;
    logic                r_ib_pv2, r_ib_cu2, r_ib_lf2, r_ib_rt2;
    logic signed [P-1:0] r_l2a, r_l2b, r_dpa, r_dpb, r_dca, r_dcb, r_opa, r_opb;
    logic signed [P-1:0] r_oca, r_ocb, r_o1a, r_o1b, r_o2a, r_o2b;
    logic signed [P-1:0] r_kpa, r_kpb, r_kca, r_kcb;
    logic [R2W-1:0]      r_r2_2, r_t2_2;

    // Stage 3: sums.
    logic                r_v3;
    t_flags              r_f3;
    logic                r_ib_pv3, r_ib_cu3, r_ib_lf3, r_ib_rt3;
    logic signed [S-1:0] r_l2, r_dp, r_dc, r_op, r_oc, r_o1, r_o2, r_kp, r_kc;
    logic [R2W-1:0]      r_r2_3, r_t2_3;

    // Stage 4: window terms and geometric decision.
    logic                r_v4;
    t_geom               r_g;

    logic signed [S:0]   w_ep, w_ec;
    logic signed [S-1:0] w_t2;
    t_flags              w_f4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1     <= '{i_kind, w_box, (lfx == rtx) && (lfy == rty),
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            r_ib_pv1 <= in_box(lfx, lfy, rtx, rty, pvx, pvy);
            r_ib_cu1 <= in_box(lfx, lfy, rtx, rty, cux, cuy);
            r_ib_lf1 <= in_box(pvx, pvy, cux, cuy, lfx, lfy);
            r_ib_rt1 <= in_box(pvx, pvy, cux, cuy, rtx, rty);
            r_gx  <= dif(rtx, lfx);
            r_gy  <= dif(rty, lfy);
            r_pdx <= dif(pvx, lfx);
            r_pdy <= dif(pvy, lfy);
            r_cdx <= dif(cux, lfx);
            r_cdy <= dif(cuy, lfy);
            r_mx  <= dif(cux, pvx);
            r_my  <= dif(cuy, pvy);
            r_lpx <= dif(lfx, pvx);
            r_lpy <= dif(lfy, pvy);
            r_rpx <= dif(rtx, pvx);
            r_rpy <= dif(rty, pvy);
            r_kpx <= dif(pvx, cpx);
            r_kpy <= dif(pvy, cpy);
            r_kcx <= dif(cux, cpx);
            r_kcy <= dif(cuy, cpy);

            r_f2 <= r_f1;
            r_ib_pv2 <= r_ib_pv1;
            r_ib_cu2 <= r_ib_cu1;
            r_ib_lf2 <= r_ib_lf1;
            r_ib_rt2 <= r_ib_rt1;
            r_l2a <= r_gx * r_gx;
            r_l2b <= r_gy * r_gy;
            r_dpa <= r_pdx * r_gx;
            r_dpb <= r_pdy * r_gy;
            r_dca <= r_cdx * r_gx;
            r_dcb <= r_cdy * r_gy;
            r_opa <= r_gx * r_pdy;
            r_opb <= r_gy * r_pdx;
            r_oca <= r_gx * r_cdy;
            r_ocb <= r_gy * r_cdx;
            r_o1a <= r_mx * r_lpy;
            r_o1b <= r_my * r_lpx;
            r_o2a <= r_mx * r_rpy;
            r_o2b <= r_my * r_rpx;
            r_kpa <= r_kpx * r_kpx;
            r_kpb <= r_kpy * r_kpy;
            r_kca <= r_kcx * r_kcx;
            r_kcb <= r_kcy * r_kcy;
            r_r2_2 <= i_radius * i_radius;
            r_t2_2 <= i_threshold * i_threshold;

            r_f3 <= r_f2;
            r_ib_pv3 <= r_ib_pv2;
            r_ib_cu3 <= r_ib_cu2;
            r_ib_lf3 <= r_ib_lf2;
            r_ib_rt3 <= r_ib_rt2;
            r_l2 <= S'(r_l2a) + S'(r_l2b);
            r_dp <= S'(r_dpa) + S'(r_dpb);
            r_dc <= S'(r_dca) + S'(r_dcb);
            r_op <= S'(r_opa) - S'(r_opb);
            r_oc <= S'(r_oca) - S'(r_ocb);
            r_o1 <= S'(r_o1a) - S'(r_o1b);
            r_o2 <= S'(r_o2a) - S'(r_o2b);
            r_kp <= S'(r_kpa) + S'(r_kpb);
            r_kc <= S'(r_kca) + S'(r_kcb);
            r_r2_3 <= r_r2_2;
            r_t2_3 <= r_t2_2;

            r_g.flags  <= w_f4;
            r_g.mag_dp <= (r_dp < 0) ? MW'(-r_dp) : '0;
            r_g.mag_dc <= (r_dc < 0) ? MW'(-r_dc) : '0;
            r_g.mag_ep <= (w_ep > 0) ? MW'(w_ep) : '0;
            r_g.mag_ec <= (w_ec > 0) ? MW'(w_ec) : '0;
            r_g.l2     <= MW'(r_l2);
            r_g.r2     <= r_r2_3;
        end
    end

    assign w_ep = (S+1)'(r_dp) - (S+1)'(r_l2);
    assign w_ec = (S+1)'(r_dc) - (S+1)'(r_l2);
    assign w_t2 = $signed(S'(r_t2_3));

    always_comb begin
        w_f4         = r_f3;
        w_f4.dp_neg  = r_dp < 0;
        w_f4.dc_neg  = r_dc < 0;
        w_f4.ep_pos  = w_ep > 0;
        w_f4.ec_pos  = w_ec > 0;
        w_f4.cp_hit  = (r_kc < w_t2) && (r_kp >= w_t2);
        w_f4.hit_geo = opp(r_op, r_oc) ||
                       ((r_o1 == 0) && r_ib_lf3) || ((r_o2 == 0) && r_ib_rt3) ||
                       ((r_op == 0) && r_ib_pv3) || ((r_oc == 0) && r_ib_cu3);
    end

    assign o_valid = r_v4;
    assign o_geom  = r_g;

endmodule

FILE: hdl/gate_crossing_detector.sv
// Gate crossing detector. Each request carries a vehicle's previous and
// current position, the two cones of a gate, a fallback checkpoint and a kind
// in s_axis_tuser; the block answers every request with one bit, crossed, on
// the master side. A checkpoint request reports entry into the capture circle
// of radius gate_threshold; a gate request runs the padded bounding-box,
// zero-length gate and padded projection window rejections before the
// orientation and segment intersection tests, all in exact integer arithmetic
// with squared comparisons in place of roots and divisions. Kind 0 and the
// unused kind 3 answer 0. The datapath is a seven-stage pipeline that accepts
// one request every clock cycle while no finished result waits on a stalled
// consumer; each result is held in the output register until it is taken. All
// stages advance together whenever the output register is empty or its result
// is taken, so s_axis_tready falls only while a finished result waits on a
// stalled consumer. The registers gate_threshold (index 0, reset 5.0) and
// vehicle_radius (index 1, reset 1.0) are 16-bit unsigned with 8 fraction
// bits and are to be written while no request is in flight.
module gate_crossing_detector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // prev_x, prev_y, curr_x, curr_y, left_x, left_y, right_x, right_y,
    // checkpoint_x, checkpoint_y; 24 bits each from the lowest bit up.
    input  logic [10*gcd_pkg::CW-1:0]    s_axis_tdata,
    // kind.
    input  logic [1:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // crossed in bit 0, upper bits zero.
    output logic [7:0]                   m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [gcd_pkg::CFG_W-1:0]    i_cfg_data
);
    import gcd_pkg::*;

    logic [CFG_W-1:0] r_threshold;
    logic [CFG_W-1:0] r_radius;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= CFG_W'(1280);
            r_radius    <= CFG_W'(256);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data;
                end
                CFG_RADIUS: begin
                    r_radius <= i_cfg_data;
                end
            endcase
        end
    end

    // The whole pipeline moves when the output register can take a result.
    logic w_en;
    logic r_v7;
    logic r_crossed;

    assign w_en          = !r_v7 || m_axis_tready;
    assign s_axis_tready = w_en;

    // Stages 1 to 4: differences, products, sums and the geometric decision.
    logic  w_v4;
    t_geom w_g;

    gcd_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (s_axis_tvalid),
        .i_kind      (t_kind'(s_axis_tuser)),
        .i_coord     (s_axis_tdata),
        .i_threshold (r_threshold),
        .i_radius    (r_radius),
        .o_valid     (w_v4),
        .o_geom      (w_g)
    );

    // Stages 5 and 6: squares of the four window terms, and the padded gate
    // length R^2 * L2 built from two partial products.
    logic [SQ-1:0]       w_sq_dp, w_sq_ep, w_sq_dc, w_sq_ec;

    gcd_sq u_sq_dp (.i_clk(i_clk), .i_en(w_en), .i_mag(w_g.mag_dp), .o_sq(w_sq_dp));
    gcd_sq u_sq_ep (.i_clk(i_clk), .i_en(w_en), .i_mag(w_g.mag_ep), .o_sq(w_sq_ep));
    gcd_sq u_sq_dc (.i_clk(i_clk), .i_en(w_en), .i_mag(w_g.mag_dc), .o_sq(w_sq_dc));
    gcd_sq u_sq_ec (.i_clk(i_clk), .i_en(w_en), .i_mag(w_g.mag_ec), .o_sq(w_sq_ec));

    logic                r_v5, r_v6;
    t_flags              r_f5, r_f6;
    logic [R2W+H-1:0]    r_pl5;
    logic [R2W+HI-1:0]   r_ph5;
    logic [SQ-1:0]       r_rl6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // A position is below the window when its projection is negative and
    // its square exceeds R^2 * L2, above it when the excess over L2 does.
    logic w_below_p, w_below_c, w_above_p, w_above_c;
    logic w_win_rej;
    logic w_gate;

    assign w_below_p = r_f6.dp_neg && (w_sq_dp > r_rl6);
    assign w_below_c = r_f6.dc_neg && (w_sq_dc > r_rl6);
    assign w_above_p = r_f6.ep_pos && (w_sq_ep > r_rl6);
    assign w_above_c = r_f6.ec_pos && (w_sq_ec > r_rl6);
    assign w_win_rej = (w_below_p && w_below_c) || (w_above_p && w_above_c);
    assign w_gate    = !r_f6.box_rej && !r_f6.zero_gate && !w_win_rej && r_f6.hit_geo;

    logic n_crossed;

    always_comb begin
        case (r_f6.kind)
            KIND_CKPT: n_crossed = r_f6.cp_hit;
            KIND_GATE: n_crossed = w_gate;
            default:   n_crossed = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f5  <= w_g.flags;
            r_pl5 <= w_g.r2 * w_g.l2[H-1:0];
            r_ph5 <= w_g.r2 * w_g.l2[MW-1:H];
            r_f6  <= r_f5;
            r_rl6 <= (SQ'(r_ph5) << H) + SQ'(r_pl5);
            r_crossed <= n_crossed;
        end
    end

    assign m_axis_tvalid = r_v7;
    assign m_axis_tdata  = {7'b0, r_crossed};

    // A waiting result must hold the input side off.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result presented straight after reset");

    // A bubble in the last internal stage leaves the output empty.
    a_bubble_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !r_v6) |=> !m_axis_tvalid)
        else $error("result invented from an empty stage");

endmodule
